/* design/ckpx_pkg.sv */
// ----------------------------------------------------------------------------
// ckpx_pkg
// Shared types and codes for the chaotic keystream pixel XOR block: the
// command bundle from the controller to the datapath and the step phase codes.
// ----------------------------------------------------------------------------
package ckpx_pkg;

    // Width of every fixed-point value and seed register.
    localparam int WORD_W  = 32;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEED_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_W = 8'd3;

    // Phases of one Euler step on the shared multiplier.
    localparam logic [PHASE_W-1:0] PH_WW     = 4'd0; // w*w, (y-z)-x, z-y
    localparam logic [PHASE_W-1:0] PH_TBZ    = 4'd1; // tb*z
    localparam logic [PHASE_W-1:0] PH_TE     = 4'd2; // t*e, aw = a + ww
    localparam logic [PHASE_W-1:0] PH_AWY    = 4'd3; // aw*y, x update
    localparam logic [PHASE_W-1:0] PH_TY     = 4'd4; // t*y, z update
    localparam logic [PHASE_W-1:0] PH_D      = 4'd5; // d = (z-y) - p
    localparam logic [PHASE_W-1:0] PH_TGD    = 4'd6; // tg*d, w update
    localparam logic [PHASE_W-1:0] PH_WAIT   = 4'd7; // rounding of tg*d
    localparam logic [PHASE_W-1:0] PH_Y      = 4'd8; // y update
    localparam logic [PHASE_W-1:0] PH_LAST   = PH_Y;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 cap_in;    // latch the pixel bytes
        logic                 load_seed; // reload the state from the seeds
        logic                 step_en;   // a step phase is active
        logic [PHASE_W-1:0]   phase;     // which step phase
        logic                 load_out;  // load the result register
    } dp_cmd_t;

endpackage

/* design/ckpx_ctrl.sv */
// ----------------------------------------------------------------------------
// ckpx_ctrl
// Controller: input and output handshakes, warm-up step counter and the
// phase sequence of each Euler step.
// ----------------------------------------------------------------------------
module ckpx_ctrl #(
    parameter int WARMUP_STEPS = 5000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              first_pixel,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output ckpx_pkg::dp_cmd_t cmd
);
    import ckpx_pkg::*;

    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(WARMUP_STEPS - 1);
    localparam logic             HAS_WARM  = (WARMUP_STEPS != 0);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               warm_reg, warm_next;
    logic               out_valid_reg, out_valid_next;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        warm_next      = warm_reg;
        cmd            = '0;
        cmd.phase      = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    phase_next = PH_WW;
                    state_next = ST_STEP;
                    if (first_pixel)
                    begin
                        cmd.load_seed = 1'b1;
                        count_next    = '0;
                        warm_next     = HAS_WARM;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step_en = 1'b1;
                if (phase_reg == PH_LAST)
                begin
                    phase_next = PH_WW;
                    if (warm_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        if (count_reg == WARM_LAST)
                        begin
                            warm_next = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register holds its beat until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WW;
            count_reg     <= '0;
            warm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            warm_reg      <= warm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/ckpx_dp.sv */
// ----------------------------------------------------------------------------
// ckpx_dp
// Datapath: seed registers, generator state, one shared 32x32 multiplier
// with a rounding and saturation stage, key extraction and the result
// register.
// ----------------------------------------------------------------------------
module ckpx_dp #(
    parameter int FRAC_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ckpx_pkg::dp_cmd_t                 cmd,
    input  logic                              cfg_we,
    input  logic [ckpx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckpx_pkg::WORD_W-1:0]       cfg_data,
    input  logic [7:0]                        channel_a,
    input  logic [7:0]                        channel_b,
    input  logic [7:0]                        channel_c,
    output logic [7:0]                        out_a,
    output logic [7:0]                        out_b,
    output logic [7:0]                        out_c,
    output logic [7:0]                        key_byte
);
    import ckpx_pkg::*;

    // Coefficients rounded to nearest at FRAC_BITS fraction bits.
    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint HALFV = longint'(1) << (FRAC_BITS - 1);
    localparam longint CT_L  = (ONE + 500) / 1000;
    localparam longint CTB_L = (15 * ONE + 500) / 1000;
    localparam longint CTG_L = (10 * ONE + 500) / 1000;
    localparam longint CA_L  = -((112 * ONE + 50) / 100);
    localparam logic signed [WORD_W-1:0] C_T  = WORD_W'(CT_L);
    localparam logic signed [WORD_W-1:0] C_TB = WORD_W'(CTB_L);
    localparam logic signed [WORD_W-1:0] C_TG = WORD_W'(CTG_L);
    localparam logic signed [WORD_W-1:0] C_A  = WORD_W'(CA_L);
    localparam logic signed [63:0]       RND_HALF = 64'(HALFV);

    // Key shifts for the scales 2^11, 2^10, 2^12 and 2^10.
    localparam int SH_X = FRAC_BITS - 11;
    localparam int SH_Y = FRAC_BITS - 10;
    localparam int SH_Z = FRAC_BITS - 12;
    localparam int SH_W = FRAC_BITS - 10;

    localparam logic signed [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    function automatic logic signed [WORD_W-1:0] sat_add(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? S_MIN : S_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sub(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b
    );
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? S_MIN : S_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // Two low bits of v / 2^sh truncated toward zero.
    function automatic logic [1:0] key2(
        input logic signed [WORD_W-1:0] v,
        input int                       sh
    );
        logic [WORD_W:0] mag;
        logic [WORD_W:0] q;
        mag = v[WORD_W-1] ? ((WORD_W+1)'(0) - {v[WORD_W-1], v}) : {1'b0, v};
        q   = mag >> sh;
        if (v[WORD_W-1])
        begin
            q = (WORD_W+1)'(0) - q;
        end
        return q[1:0];
    endfunction

    logic signed [WORD_W-1:0] seed_x_reg, seed_y_reg, seed_z_reg, seed_w_reg;
    logic signed [WORD_W-1:0] x_reg, y_reg, z_reg, w_reg;
    logic signed [WORD_W-1:0] e_reg, zy_reg, aw_reg, d_reg, rnd_reg;
    logic signed [63:0]       prod_reg;
    logic signed [WORD_W-1:0] op_a, op_b, rnd_next;
    logic signed [63:0]       prod_next, biased, shifted;
    logic [7:0]               ch_a_reg, ch_b_reg, ch_c_reg;
    logic [7:0]               out_a_reg, out_b_reg, out_c_reg, key_reg;
    logic [7:0]               key_now;

    // Seed registers, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_x_reg <= '0;
            seed_y_reg <= '0;
            seed_z_reg <= '0;
            seed_w_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED_X: seed_x_reg <= cfg_data;
                REG_SEED_Y: seed_y_reg <= cfg_data;
                REG_SEED_Z: seed_z_reg <= cfg_data;
                REG_SEED_W: seed_w_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Multiplier operand selection by step phase.
    always_comb
    begin
        case (cmd.phase)
            PH_WW:
            begin
                op_a = w_reg;
                op_b = w_reg;
            end
            PH_TBZ:
            begin
                op_a = C_TB;
                op_b = z_reg;
            end
            PH_TE:
            begin
                op_a = C_T;
                op_b = e_reg;
            end
            PH_AWY:
            begin
                op_a = aw_reg;
                op_b = y_reg;
            end
            PH_TY:
            begin
                op_a = C_T;
                op_b = y_reg;
            end
            PH_TGD:
            begin
                op_a = C_TG;
                op_b = d_reg;
            end
            default:
            begin
                op_a = w_reg;
                op_b = w_reg;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Round to nearest, ties up, then saturate to the word range.
    always_comb
    begin
        biased  = prod_reg + RND_HALF;
        shifted = biased >>> FRAC_BITS;
        if (shifted > 64'(S_MAX))
        begin
            rnd_next = S_MAX;
        end
        else if (shifted < 64'(S_MIN))
        begin
            rnd_next = S_MIN;
        end
        else
        begin
            rnd_next = shifted[WORD_W-1:0];
        end
    end

    // Product and rounding pipeline runs every cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
    end

    // Intermediate terms of the step.
    always_ff @(posedge clk)
    begin
        if (cmd.step_en)
        begin
            case (cmd.phase)
                PH_WW:
                begin
                    e_reg  <= sat_sub(sat_sub(y_reg, z_reg), x_reg);
                    zy_reg <= sat_sub(z_reg, y_reg);
                end
                PH_TE:   aw_reg <= sat_add(C_A, rnd_reg);
                PH_D:    d_reg  <= sat_sub(zy_reg, rnd_reg);
                default: ;
            endcase
        end
    end

    // Generator state: reloaded from the seeds or updated once per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            w_reg <= '0;
        end
        else if (cmd.load_seed)
        begin
            x_reg <= seed_x_reg;
            y_reg <= seed_y_reg;
            z_reg <= seed_z_reg;
            w_reg <= seed_w_reg;
        end
        else if (cmd.step_en)
        begin
            case (cmd.phase)
                PH_AWY:  x_reg <= sat_add(x_reg, rnd_reg);
                PH_TY:   z_reg <= sat_add(z_reg, rnd_reg);
                PH_TGD:  w_reg <= sat_add(w_reg, rnd_reg);
                PH_Y:    y_reg <= sat_add(y_reg, rnd_reg);
                default: ;
            endcase
        end
    end

    // Key byte from the new state, x in the top bits.
    assign key_now = {key2(x_reg, SH_X), key2(y_reg, SH_Y),
                      key2(z_reg, SH_Z), key2(w_reg, SH_W)};

    // Pixel bytes and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            ch_a_reg <= channel_a;
            ch_b_reg <= channel_b;
            ch_c_reg <= channel_c;
        end
        if (cmd.load_out)
        begin
            out_a_reg <= ch_a_reg ^ key_now;
            out_b_reg <= ch_b_reg ^ key_now;
            out_c_reg <= ch_c_reg ^ key_now;
            key_reg   <= key_now;
        end
    end

    assign out_a    = out_a_reg;
    assign out_b    = out_b_reg;
    assign out_c    = out_c_reg;
    assign key_byte = key_reg;

endmodule

/* design/chaotic_keystream_pixel_xor.sv */
// ----------------------------------------------------------------------------
// chaotic_keystream_pixel_xor
// XORs each pixel's three bytes with a key byte drawn from a four-variable
// chaotic generator in saturating signed fixed point.
// ----------------------------------------------------------------------------
// After acceptance, a pixel runs one Euler step through the phases PH_WW to
// PH_Y on the single shared multiplier (multiply, then a rounding stage, with
// the w*w, a+ww, times y, times gamma chain setting the length). Then the
// result register is loaded, which waits while a held result is still stalled
// at the output. The next pixel is taken in the idle state after that load, so
// a new pixel is not accepted before the previous one is through. A pixel
// marked first_pixel reloads the seeds and first runs WARMUP_STEPS warm-up
// steps before its own step. A new pixel is accepted once the previous result
// sits in the output register, even if the sink still stalls it. Seed writes
// take effect at the next first pixel.
module chaotic_keystream_pixel_xor #(
    parameter int WARMUP_STEPS = 5000,
    parameter int FRAC_BITS    = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     channel_a,
    input  logic [7:0]                     channel_b,
    input  logic [7:0]                     channel_c,
    input  logic                           first_pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_a,
    output logic [7:0]                     out_b,
    output logic [7:0]                     out_c,
    output logic [7:0]                     key_byte,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ckpx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ckpx_pkg::WORD_W-1:0]    cfg_data
);
    import ckpx_pkg::*;

    dp_cmd_t cmd;

    // Seeds must be written while idle; the block does not enforce this, and the port never holds off.
    assign cfg_ready = 1'b1;

    ckpx_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .first_pixel (first_pixel),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    ckpx_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .channel_a (channel_a),
        .channel_b (channel_b),
        .channel_c (channel_c),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .key_byte  (key_byte)
    );

endmodule

/* design/ckpx_checker.sv */
// ----------------------------------------------------------------------------
// ckpx_checker
// Port-level checks for the chaotic keystream pixel XOR block, bound to the
// top level.
// ----------------------------------------------------------------------------
module ckpx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_a,
    input logic [7:0] key_byte
);

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_a) && $stable(key_byte))
        else $error("result beat changed while stalled");

    // Once a pixel is accepted, the block holds off the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a pixel was accepted");

    // A new result appears only while a pixel is being worked on.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a pixel in progress");

    // The input reopens only when the finished result has been loaded.
    a_reopen_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input reopened without a result beat");

endmodule

bind chaotic_keystream_pixel_xor ckpx_checker u_ckpx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_a     (out_a),
    .key_byte  (key_byte)
);
